// ===== design/acm_pkg.sv =====
// Shared constants and helper functions for the constellation mapper.
`timescale 1ns / 1ps

package acm_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_POINTS_DEF   = 256;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Operation codes carried in s_tuser
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEMAP = 2'd2;

    // Field widths
    localparam int IDX_W      = 8;
    localparam int BPS_W      = 4;
    localparam int BPS_MAX    = 8;
    localparam int SOFT_LANES = 8;
    localparam int SOFT_W     = 64;
    localparam logic [BPS_W-1:0] BPS_RESET = 4'd4;

    // Distances carry 26 fraction bits; each per-bit minimum starts at 4.0
    localparam int DIST_START_SHIFT = 28;
    localparam int DIST_START_W     = 29;
    // d0 - d1 of two minima that never exceed 4.0
    localparam int SD_W = 30;

    // Soft value: trunc((d0 - d1) * 96 * M / (5 << 26)) + 127, clamped
    localparam int SOFT_SCALE  = 96;
    localparam int SCALE_W     = 16;
    localparam int SOFT_SHIFT  = 26;
    localparam int SOFT_T_W    = 10;
    localparam int RECIP_5     = 205;
    localparam int RECIP_SHIFT = 10;
    localparam int SOFT_MID    = 127;
    localparam int SOFT_MAX    = 255;
    localparam int SOFT_STEPS  = 10;
    localparam int SOFT_CNT_W  = 4;

    // Clamp a written bits_per_symbol into 1..8
    function automatic logic [BPS_W-1:0] eff_bits(input logic [BPS_W-1:0] v);
        logic [BPS_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = BPS_W'(1);
        end else if (v > BPS_W'(BPS_MAX)) begin
            r = BPS_W'(BPS_MAX);
        end
        return r;
    endfunction

    // t = |num| >> 26 (clamped to 10 bits); divide by 5 through the
    // reciprocal, then offset and clamp into a byte
    function automatic logic [7:0] soft_byte(input logic neg,
                                             input logic [SOFT_T_W-1:0] t);
        logic [SOFT_T_W+8-1:0] p;
        logic [7:0]            q;
        logic [7:0]            r;
        p = (SOFT_T_W+8)'(t) * (SOFT_T_W+8)'(RECIP_5);
        q = 8'(p >> RECIP_SHIFT);
        if (neg) begin
            r = (q > 8'(SOFT_MID)) ? 8'd0 : 8'(SOFT_MID) - q;
        end else begin
            r = (q > 8'(SOFT_MAX - SOFT_MID)) ? 8'(SOFT_MAX) : 8'(SOFT_MID) + q;
        end
        return r;
    endfunction

endpackage

// ===== design/acm_point_ram.sv =====
// Constellation point table: one write port, one registered read port.
`timescale 1ns / 1ps

module acm_point_ram #(
    parameter int DEPTH  = acm_pkg::MAX_POINTS_DEF,
    parameter int DATA_W = 2 * acm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write and read both on the clock; read data is registered
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/arbitrary_constellation_mapper.sv =====
// A table write is done in its accept cycle. A map result is formed in ST_MAP and a demap
// result in ST_SEARCH (over the M table points in use) and ST_SOFT; both then pass ST_DONE
// to the output register. One item at a time: the next item is taken the cycle after the result is
// handed to the output register. Each distance is squared in two parts on one shared multiplier.
// Reset: aresetn (synchronous, active low) clears the sequencer, the output beat and sets
// bits_per_symbol to 4; the point table is not cleared and must be written before use.
`timescale 1ns / 1ps

module arbitrary_constellation_mapper #(
    parameter int MAX_POINTS   = acm_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_WIDTH = acm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    // Configuration: bits_per_symbol
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [acm_pkg::BPS_W-1:0]       cfg_data,

    // Input beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: index, sample_i, sample_q (low to high), zero padded
    input  logic [((acm_pkg::IDX_W + 2*SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: mode
    input  logic [acm_pkg::MODE_W-1:0]      s_tuser,

    // Result beats
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: symbol, point_i, point_q, soft_bits (low to high), zero padded
    output logic [((acm_pkg::IDX_W + 2*SAMPLE_WIDTH + acm_pkg::SOFT_W + 7) / 8) * 8 - 1:0]
                                            m_tdata,
    // tuser: error
    output logic [0:0]                      m_tuser
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int AW      = $clog2(MAX_POINTS);
    localparam int PTS_W   = $clog2(MAX_POINTS + 1);
    localparam int STEP_W  = AW + 2;
    localparam int DIFF_W  = SW + 1;
    localparam int DW      = (2*SW + 1 > acm_pkg::DIST_START_W) ?
                             2*SW + 1 : acm_pkg::DIST_START_W;
    localparam int MUL_W   = (DIFF_W > acm_pkg::SD_W) ? DIFF_W : acm_pkg::SD_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int OUT_W   = ((acm_pkg::IDX_W + 2*SW + acm_pkg::SOFT_W + 7) / 8) * 8;
    localparam int SOFT_LO = acm_pkg::IDX_W + 2*SW;
    localparam logic [DW-1:0] DIST_START = DW'(64'd1 << acm_pkg::DIST_START_SHIFT);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MAP    = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_SOFT   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]                    state_reg;
    logic [acm_pkg::BPS_W-1:0]     bps_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [acm_pkg::SOFT_CNT_W-1:0] soft_cnt_reg;

    logic [acm_pkg::IDX_W-1:0]     idx_reg;
    logic signed [SW-1:0]          x_i_reg, x_q_reg;
    logic signed [DIFF_W-1:0]      di_reg, dq_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic [DW-1:0]                 acc_reg;
    logic [DW-1:0]                 best_d_reg;
    logic [AW-1:0]                 best_reg;
    logic [DW-1:0]                 dmin0_reg [acm_pkg::SOFT_LANES];
    logic [DW-1:0]                 dmin1_reg [acm_pkg::SOFT_LANES];
    logic signed [acm_pkg::SD_W-1:0] sd_reg;

    logic [acm_pkg::IDX_W-1:0]     res_sym_reg;
    logic [2*SW-1:0]               res_pt_reg;
    logic [acm_pkg::SOFT_W-1:0]    res_soft_reg;
    logic                          res_err_reg;

    logic                          m_tvalid_reg;
    logic [OUT_W-1:0]              m_tdata_reg;
    logic                          m_err_reg;

    // Input beat fields
    logic                          s_acc;
    logic [acm_pkg::IDX_W-1:0]     s_idx;
    logic signed [SW-1:0]          s_i, s_q;

    assign s_idx = s_tdata[acm_pkg::IDX_W-1:0];
    assign s_i   = s_tdata[acm_pkg::IDX_W +: SW];
    assign s_q   = s_tdata[acm_pkg::IDX_W + SW +: SW];
    assign s_acc = s_tvalid && s_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Constellation size in use and soft scale 96 * M
    logic [8:0]                    pow_pts;
    logic [PTS_W-1:0]              pts;
    logic [acm_pkg::SCALE_W-1:0]   scale;
    logic [STEP_W-1:0]             search_last;

    assign pow_pts     = 9'(1) << bps_reg;
    assign pts         = (pow_pts > 9'(MAX_POINTS)) ? PTS_W'(MAX_POINTS) : PTS_W'(pow_pts);
    assign scale       = acm_pkg::SCALE_W'(acm_pkg::SOFT_SCALE)
                         * acm_pkg::SCALE_W'(pts);
    assign search_last = STEP_W'({pts, 1'b0}) + STEP_W'(2);

    // Point table
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    logic [2*SW-1:0]   ram_rdata;
    logic signed [SW-1:0] rd_i, rd_q;

    assign ram_we = s_acc && (s_tuser == acm_pkg::MODE_WRITE)
                    && ({1'b0, s_idx} < 9'(MAX_POINTS));
    assign rd_i   = ram_rdata[SW-1:0];
    assign rd_q   = ram_rdata[2*SW-1:SW];

    always_comb begin
        unique case (state_reg)
            ST_IDLE:   ram_raddr = s_idx[AW-1:0];
            ST_SEARCH: ram_raddr = step_reg[AW:1];
            default:   ram_raddr = best_reg;
        endcase
    end

    acm_point_ram #(
        .DEPTH  (MAX_POINTS),
        .DATA_W (2*SW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (s_idx[AW-1:0]),
        .wr_data ({s_q, s_i}),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Shared multiplier: squares di/dq while searching, scales d0 - d1 for soft values
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb begin
        if (state_reg == ST_SOFT) begin
            mul_a = MUL_W'(sd_reg);
            mul_b = MUL_W'(scale);
        end else if (step_reg[0]) begin
            mul_a = MUL_W'(dq_reg);
            mul_b = MUL_W'(dq_reg);
        end else begin
            mul_a = MUL_W'(di_reg);
            mul_b = MUL_W'(di_reg);
        end
    end

    assign mul_p = mul_a * mul_b;

    // Search: point n is read at step 2n, differenced at 2n+1, squared at 2n+2 and
    // 2n+3, and compared at 2n+4
    logic                      upd;
    logic [AW-1:0]             upd_idx;
    logic [acm_pkg::IDX_W-1:0] idx_sh;
    logic [DW-1:0]             dist_sum;

    assign upd     = (state_reg == ST_SEARCH) && !step_reg[0] && (step_reg >= STEP_W'(4));
    assign upd_idx = AW'(step_reg[STEP_W-1:1] - (STEP_W-1)'(2));
    assign idx_sh  = acm_pkg::IDX_W'(upd_idx)
                     << (acm_pkg::BPS_W'(acm_pkg::BPS_MAX) - bps_reg);
    assign dist_sum = acc_reg + prod_reg[DW-1:0];

    // Soft value from the registered scaled difference
    logic [2:0]                  soft_lane;
    logic                        soft_neg;
    logic [PROD_W-1:0]           soft_mag;
    logic [PROD_W-1:0]           soft_t_full;
    logic [acm_pkg::SOFT_T_W-1:0] soft_t;
    logic [7:0]                  soft_val;
    logic signed [acm_pkg::SD_W-1:0] sd_next;

    assign soft_lane   = 3'(soft_cnt_reg - acm_pkg::SOFT_CNT_W'(2));
    assign soft_neg    = prod_reg[PROD_W-1];
    assign soft_mag    = soft_neg ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign soft_t_full = soft_mag >> acm_pkg::SOFT_SHIFT;
    assign soft_t      = (|soft_t_full[PROD_W-1:acm_pkg::SOFT_T_W]) ?
                         '1 : soft_t_full[acm_pkg::SOFT_T_W-1:0];
    assign soft_val    = ({1'b0, soft_lane} < bps_reg) ?
                         acm_pkg::soft_byte(soft_neg, soft_t) : 8'd0;
    assign sd_next     = acm_pkg::SD_W'(dmin0_reg[soft_cnt_reg[2:0]])
                         - acm_pkg::SD_W'(dmin1_reg[soft_cnt_reg[2:0]]);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bps_reg      <= acm_pkg::BPS_RESET;
            m_tvalid_reg <= 1'b0;
            step_reg     <= '0;
            soft_cnt_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                bps_reg <= acm_pkg::eff_bits(cfg_data);
            end
            // output beat: load a finished result, or drop the one just taken
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    step_reg <= '0;
                    if (s_acc && s_tuser == acm_pkg::MODE_MAP) begin
                        state_reg <= ST_MAP;
                    end else if (s_acc && s_tuser == acm_pkg::MODE_DEMAP) begin
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_MAP: begin
                    state_reg <= ST_DONE;
                end
                ST_SEARCH: begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == search_last) begin
                        state_reg    <= ST_SOFT;
                        soft_cnt_reg <= '0;
                    end
                end
                ST_SOFT: begin
                    soft_cnt_reg <= soft_cnt_reg + acm_pkg::SOFT_CNT_W'(1);
                    if (soft_cnt_reg == acm_pkg::SOFT_CNT_W'(acm_pkg::SOFT_STEPS - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        // capture the item
        if (s_acc) begin
            idx_reg <= s_idx;
            x_i_reg <= s_i;
            x_q_reg <= s_q;
            for (int k = 0; k < acm_pkg::SOFT_LANES; k++) begin
                dmin0_reg[k] <= DIST_START;
                dmin1_reg[k] <= DIST_START;
            end
        end

        // shared multiplier and difference stage
        prod_reg <= mul_p;
        if (step_reg[0]) begin
            di_reg  <= DIFF_W'(x_i_reg) - DIFF_W'(rd_i);
            dq_reg  <= DIFF_W'(x_q_reg) - DIFF_W'(rd_q);
            acc_reg <= prod_reg[DW-1:0];
        end

        // hard decision and per-bit minima
        if (upd) begin
            if (upd_idx == '0 || dist_sum < best_d_reg) begin
                best_reg   <= upd_idx;
                best_d_reg <= dist_sum;
            end
            for (int k = 0; k < acm_pkg::SOFT_LANES; k++) begin
                if (idx_sh[acm_pkg::SOFT_LANES-1-k]) begin
                    if (dist_sum < dmin1_reg[k]) begin
                        dmin1_reg[k] <= dist_sum;
                    end
                end else begin
                    if (dist_sum < dmin0_reg[k]) begin
                        dmin0_reg[k] <= dist_sum;
                    end
                end
            end
        end

        // map result
        if (state_reg == ST_MAP) begin
            res_sym_reg  <= idx_reg;
            res_soft_reg <= '0;
            if ({1'b0, idx_reg} >= 9'(pts)) begin
                res_err_reg <= 1'b1;
                res_pt_reg  <= '0;
            end else begin
                res_err_reg <= 1'b0;
                res_pt_reg  <= ram_rdata;
            end
        end

        // soft pass: difference, scale, then byte; best point read alongside
        if (state_reg == ST_SOFT) begin
            sd_reg <= sd_next;
            if (soft_cnt_reg == acm_pkg::SOFT_CNT_W'(1)) begin
                res_pt_reg <= ram_rdata;
            end
            if (soft_cnt_reg >= acm_pkg::SOFT_CNT_W'(2)) begin
                res_soft_reg[8*soft_lane +: 8] <= soft_val;
            end
            res_sym_reg <= acm_pkg::IDX_W'(best_reg);
            res_err_reg <= 1'b0;
        end

        // output register
        if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= OUT_W'({res_soft_reg, res_pt_reg, res_sym_reg});
            m_err_reg   <= res_err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_err_reg;

    // Checks
    a_search_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |-> step_reg <= search_last)
        else $error("search step ran past the last point");

    a_busy_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_tuser == acm_pkg::MODE_MAP || s_tuser == acm_pkg::MODE_DEMAP)
        |=> state_reg != ST_IDLE)
        else $error("map or demap item did not start work");

    a_write_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser == acm_pkg::MODE_WRITE |=> state_reg == ST_IDLE)
        else $error("table write left idle");

    a_best_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SOFT |-> PTS_W'(best_reg) < pts)
        else $error("hard decision beyond constellation size");

    a_unused_soft_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) && bps_reg < acm_pkg::BPS_W'(acm_pkg::BPS_MAX)
        |-> (m_tdata_reg[SOFT_LO +: acm_pkg::SOFT_W] >> {bps_reg, 3'b000}) == '0)
        else $error("soft byte beyond bits_per_symbol not zero");

endmodule

// ===== test/testbench.sv =====
// Stream testbench for arbitrary_constellation_mapper with a self-checking scoreboard.
`timescale 1ns / 1ps

module testbench;

    localparam int     NPTS_MAX   = 256;
    localparam int     S_W        = 40;
    localparam int     M_W        = 104;
    localparam int     IDLE_LIMIT = 4000;
    localparam int     HOLD_AT    = 25;
    localparam int     HOLD_LEN   = 400;
    localparam int     MIX_ITEMS  = 123;
    localparam int     PAUSE      = 2 * NPTS_MAX + 20;
    localparam longint DIST_INIT  = longint'(4) <<< 26;
    localparam longint SOFT_DIV   = longint'(5) <<< 26;
    // unused opcode, the block drops it
    localparam logic [acm_pkg::MODE_W-1:0] MODE_NONE = 2'd3;

    typedef struct {
        logic [7:0]  symbol;
        logic [15:0] point_i;
        logic [15:0] point_q;
        logic [63:0] soft_bits;
        logic        error;
    } mapper_result_t;

    // Scoreboard: mirrors the point table and bits_per_symbol, queues expected beats
    class constellation_scoreboard;
        logic signed [15:0] pt_i [NPTS_MAX];
        logic signed [15:0] pt_q [NPTS_MAX];
        logic [3:0]         bits_reg;
        mapper_result_t     pending [$];
        int                 mismatches;

        function new();
            bits_reg   = acm_pkg::BPS_RESET;
            mismatches = 0;
        endfunction

        function void set_bits(logic [3:0] v);
            bits_reg = v;
        endfunction

        // 0 acts as 1, anything above 8 as 8
        function int active_bits();
            if (bits_reg == 4'd0) return 1;
            if (bits_reg > 4'd8) return 8;
            return int'(bits_reg);
        endfunction

        function void note_symbol_in(logic [1:0] mode, logic [7:0] idx,
                                     logic signed [15:0] si, logic signed [15:0] sq);
            mapper_result_t r;
            int             nbits, npts, best, i, k;
            longint         d, d_best, di, dq, num, q;
            longint         d0 [8];
            longint         d1 [8];
            nbits       = active_bits();
            npts        = 1 << nbits;
            r.symbol    = idx;
            r.point_i   = '0;
            r.point_q   = '0;
            r.soft_bits = '0;
            r.error     = 1'b0;
            case (mode)
                acm_pkg::MODE_WRITE: begin
                    pt_i[idx] = si;
                    pt_q[idx] = sq;
                    return;
                end
                acm_pkg::MODE_MAP: begin
                    if (int'(idx) >= npts) begin
                        r.error = 1'b1;
                    end else begin
                        r.point_i = pt_i[idx];
                        r.point_q = pt_q[idx];
                    end
                end
                acm_pkg::MODE_DEMAP: begin
                    best   = 0;
                    d_best = 0;
                    for (k = 0; k < 8; k++) begin
                        d0[k] = DIST_INIT;
                        d1[k] = DIST_INIT;
                    end
                    // exhaustive search, first minimum keeps the decision
                    for (i = 0; i < npts; i++) begin
                        di = longint'(si) - longint'(pt_i[i]);
                        dq = longint'(sq) - longint'(pt_q[i]);
                        d  = di * di + dq * dq;
                        if (i == 0 || d < d_best) begin
                            best   = i;
                            d_best = d;
                        end
                        for (k = 0; k < nbits; k++) begin
                            if (((i >> (nbits - k - 1)) & 1) != 0) begin
                                if (d < d1[k]) d1[k] = d;
                            end else begin
                                if (d < d0[k]) d0[k] = d;
                            end
                        end
                    end
                    // soft byte per bit, MSB in byte 0; division truncates toward zero
                    for (k = 0; k < nbits; k++) begin
                        num = (d0[k] - d1[k]) * acm_pkg::SOFT_SCALE * npts;
                        q   = num / SOFT_DIV + acm_pkg::SOFT_MID;
                        if (q > acm_pkg::SOFT_MAX) q = acm_pkg::SOFT_MAX;
                        if (q < 0) q = 0;
                        r.soft_bits[8*k +: 8] = q[7:0];
                    end
                    r.symbol  = 8'(best);
                    r.point_i = pt_i[best];
                    r.point_q = pt_q[best];
                end
                default: return;
            endcase
            pending.push_back(r);
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s expected %h got %h", $time, field, want, got);
            end
        endfunction

        function void check_symbol_out(logic [M_W-1:0] data, logic err);
            mapper_result_t want;
            if (pending.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none got %h / %b",
                         $time, data, err);
                return;
            end
            want = pending.pop_front();
            compare("symbol", want.symbol, data[7:0]);
            compare("point_i", want.point_i, data[23:8]);
            compare("point_q", want.point_q, data[39:24]);
            compare("soft_bits", want.soft_bits, data[103:40]);
            compare("error", want.error, err);
        endfunction
    endclass

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [acm_pkg::BPS_W-1:0]   cfg_data;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [S_W-1:0]              s_tdata;   // index, sample_i, sample_q
    logic [acm_pkg::MODE_W-1:0]  s_tuser;   // mode
    logic                        m_tvalid;
    logic                        m_tready;
    logic [M_W-1:0]              m_tdata;   // symbol, point_i, point_q, soft_bits
    logic [0:0]                  m_tuser;   // error

    constellation_scoreboard book;
    bit send_burst = 1'b0;
    bit take_burst = 1'b0;
    int results_seen = 0;

    arbitrary_constellation_mapper dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [15:0] clip_sample(int v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    // Point styles: 0 spread within +-1.5, 1 coarse grid (ties), 2 full range
    function automatic logic [31:0] random_point(int style);
        int vi, vq;
        case (style)
            0: begin
                vi = int'($urandom_range(0, 24000)) - 12000;
                vq = int'($urandom_range(0, 24000)) - 12000;
            end
            1: begin
                vi = (int'($urandom_range(0, 4)) - 2) * 4096;
                vq = (int'($urandom_range(0, 4)) - 2) * 4096;
            end
            default: begin
                vi = int'($urandom_range(0, 65535)) - 32768;
                vq = int'($urandom_range(0, 65535)) - 32768;
            end
        endcase
        return {vq[15:0], vi[15:0]};
    endfunction

    // One input beat; returns at the edge it is taken, valid left high
    task automatic send_item(input logic [1:0] mode, input logic [7:0] idx,
                             input logic [15:0] si, input logic [15:0] sq);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {sq, si, idx};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        book.note_symbol_in(mode, idx, si, sq);
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    endtask

    task automatic write_bits(input logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        book.set_bits(v);
    endtask

    // Drain all expected beats, then give write-only beats time to finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (book.pending.size() != 0) @(posedge aclk);
        repeat (PAUSE) @(posedge aclk);
    endtask

    task automatic load_constellation(input int npts, input int style);
        logic [31:0] pt;
        for (int i = 0; i < npts; i++) begin
            pt = random_point(style);
            send_item(acm_pkg::MODE_WRITE, 8'(i), pt[15:0], pt[31:16]);
        end
    endtask

    // Random mix: mostly maps and demaps around table points, some writes and noise
    task automatic random_item(input int npts);
        int          roll, j;
        logic [31:0] pt;
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            send_item(MODE_NONE, 8'($urandom), 16'($urandom), 16'($urandom));
        end else if (roll < 24) begin
            pt = random_point($urandom_range(0, 2));
            send_item(acm_pkg::MODE_WRITE, 8'($urandom), pt[15:0], pt[31:16]);
        end else if (roll < 50) begin
            j = (roll < 44) ? $urandom_range(0, npts - 1) : $urandom_range(0, 255);
            send_item(acm_pkg::MODE_MAP, 8'(j), 16'($urandom), 16'($urandom));
        end else if ($urandom_range(0, 7) == 0) begin
            send_item(acm_pkg::MODE_DEMAP, 8'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            j = $urandom_range(0, npts - 1);
            send_item(acm_pkg::MODE_DEMAP, 8'($urandom),
                      clip_sample(int'(book.pt_i[j]) + int'($urandom_range(0, 6000)) - 3000),
                      clip_sample(int'(book.pt_q[j]) + int'($urandom_range(0, 6000)) - 3000));
        end
    endtask

    // Stimulus
    initial begin
        int         lvl [4];
        logic [3:0] phase_bits [11];
        int         nbits, last_bits;
        book      = new();
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 16-point grid at reset setting, entries 0 and 15 at the sample extremes,
        // entry 9 duplicates entry 8 so a demap there must pick 8
        lvl = '{-6144, -2048, 2048, 6144};
        for (int i = 0; i < 16; i++) begin
            if (i == 0)
                send_item(acm_pkg::MODE_WRITE, 8'd0, 16'h8000, 16'h8000);
            else if (i == 15)
                send_item(acm_pkg::MODE_WRITE, 8'd15, 16'h7fff, 16'h7fff);
            else if (i == 9)
                send_item(acm_pkg::MODE_WRITE, 8'd9, 16'(lvl[2]), 16'(lvl[0]));
            else
                send_item(acm_pkg::MODE_WRITE, 8'(i), 16'(lvl[i / 4]), 16'(lvl[i % 4]));
        end

        // directed: entries above M, maps in and out of range, dropped opcode,
        // demaps at the extremes, on a tie and near a point
        send_item(acm_pkg::MODE_WRITE, 8'd255, 16'h7fff, 16'h8000);
        send_item(acm_pkg::MODE_WRITE, 8'd128, 16'hffff, 16'h0000);
        send_item(acm_pkg::MODE_MAP, 8'd0, 16'($urandom), 16'($urandom));
        send_item(acm_pkg::MODE_MAP, 8'd15, 16'($urandom), 16'($urandom));
        send_item(acm_pkg::MODE_MAP, 8'd9, 16'($urandom), 16'($urandom));
        send_item(acm_pkg::MODE_MAP, 8'd16, 16'($urandom), 16'($urandom));
        send_item(acm_pkg::MODE_MAP, 8'd255, 16'($urandom), 16'($urandom));
        send_item(MODE_NONE, 8'hff, 16'hffff, 16'hffff);
        send_item(acm_pkg::MODE_DEMAP, 8'd0, 16'h0000, 16'h0000);
        send_item(acm_pkg::MODE_DEMAP, 8'd0, 16'h7fff, 16'h7fff);
        send_item(acm_pkg::MODE_DEMAP, 8'd0, 16'h8000, 16'h8000);
        send_item(acm_pkg::MODE_DEMAP, 8'd0, 16'h7fff, 16'h8000);
        send_item(acm_pkg::MODE_DEMAP, 8'd0, 16'h8000, 16'h7fff);
        send_item(acm_pkg::MODE_DEMAP, 8'd0, 16'(lvl[2]), 16'(lvl[0]));
        send_item(acm_pkg::MODE_DEMAP, 8'd0, 16'(lvl[1] + 300), 16'(lvl[1] - 200));

        // settings sweep; fresh constellation whenever the size changes
        phase_bits = '{4'd1, 4'd2, 4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8, 4'd15, 4'd4, 4'd2};
        last_bits  = book.active_bits();
        foreach (phase_bits[p]) begin
            settle();
            write_bits(phase_bits[p]);
            nbits = book.active_bits();
            if (nbits != last_bits) load_constellation(1 << nbits, $urandom_range(0, 2));
            last_bits = nbits;
            repeat (MIX_ITEMS) random_item(1 << nbits);
        end

        settle();
        if (book.mismatches == 0 && book.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Result side: random stalls, one long hold so the block backs up
    initial begin
        int              gap;
        bit              held;
        logic [M_W-1:0]  beat;
        logic            beat_err;
        held     = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!held && results_seen == HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end else begin
                gap = take_burst ? 0 : $urandom_range(0, 10);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_tvalid);
            beat     = m_tdata;
            beat_err = m_tuser[0];
            @(posedge aclk);
            book.check_symbol_out(beat, beat_err);
            results_seen++;
            if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
        end
    end

    // Watchdog: cycles without any beat on any channel
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(negedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/acm_pkg.sv
design/acm_point_ram.sv
design/arbitrary_constellation_mapper.sv
test/testbench.sv
